/* rtl/bale_pkg.sv */
// ----------------------------------------------------------------------------
// bale_pkg
// Shared widths, action and status codes, and the command/status bundles
// that pass between the list controller and its datapath.
// ----------------------------------------------------------------------------
package bale_pkg;

    // Field widths
    localparam int ACT_W     = 4;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 8;
    localparam int AMT_W     = 8;
    localparam int ST_W      = 3;
    localparam int IDX_OUT_W = 4;
    localparam int CNT_OUT_W = 5;

    // Default list depth and longest listing run
    localparam int DEF_CAPACITY = 16;
    localparam int LIST_MAX     = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 4'd0;
    localparam logic [ACT_W-1:0] ACT_INS_BACK  = 4'd1;
    localparam logic [ACT_W-1:0] ACT_INS_AT    = 4'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_BACK  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_AT    = 4'd5;
    localparam logic [ACT_W-1:0] ACT_SEARCH    = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LIST_ALL  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_ROTATE    = 4'd8;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic            req_load;    // latch the request fields
        logic            rd_en;       // read both banks
        logic            wr_en;       // write one bank
        logic            wr_other;    // write the inactive bank (rotate)
        logic            wr_item;     // write data is the request value
        logic            cap_removed; // hold read data as the removed value
        logic            clr_removed; // zero the removed value
        logic            cnt_inc;
        logic            cnt_dec;
        logic            bank_flip;
        logic            mod_start;   // start amount mod count
        logic            out_load;    // load the result register
        logic            out_list;    // result value from read data
        logic [ST_W-1:0] out_status;
        logic            out_last;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] position;
        logic             rd_match;
        logic             out_free;
        logic             mod_done;
    } dp_stat_t;

endpackage

/* rtl/bale_req_if.sv */
// ----------------------------------------------------------------------------
// bale_req_if
// Request channel: one list action per transfer.
// ----------------------------------------------------------------------------
interface bale_req_if;
    logic                             valid;
    logic                             ready;
    logic [bale_pkg::ACT_W-1:0]       action;
    logic signed [bale_pkg::VAL_W-1:0] item_value;
    logic [bale_pkg::POS_W-1:0]       position;
    logic [bale_pkg::AMT_W-1:0]       rotate_amount;

    modport source (output valid, action, item_value, position, rotate_amount,
                    input ready);
    modport sink   (input valid, action, item_value, position, rotate_amount,
                    output ready);
endinterface

/* rtl/bale_rsp_if.sv */
// ----------------------------------------------------------------------------
// bale_rsp_if
// Result channel: one result per transfer, a run of them for a listing.
// ----------------------------------------------------------------------------
interface bale_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [bale_pkg::ST_W-1:0]             status;
    logic signed [bale_pkg::VAL_W-1:0]     result_value;
    logic [bale_pkg::IDX_OUT_W-1:0]        result_index;
    logic [bale_pkg::CNT_OUT_W-1:0]        entries_now;
    logic                                  last_of_run;

    modport source (output valid, status, result_value, result_index, entries_now,
                    last_of_run, input ready);
    modport sink   (input valid, status, result_value, result_index, entries_now,
                    last_of_run, output ready);
endinterface

/* rtl/bale_mod.sv */
// ----------------------------------------------------------------------------
// bale_mod
// Restoring remainder unit: rotate amount modulo entry count, one dividend
// bit per cycle.
// ----------------------------------------------------------------------------
module bale_mod #(
    parameter int CW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bale_pkg::AMT_W-1:0]  dividend,
    input  logic [CW-1:0]               divisor,
    output logic                        done,
    output logic [CW-1:0]               rem
);

    localparam int SW = (bale_pkg::AMT_W > 1) ? $clog2(bale_pkg::AMT_W) : 1;

    logic                        busy_reg;
    logic                        done_reg;
    logic [SW-1:0]               step_reg;
    logic [bale_pkg::AMT_W-1:0]  dvd_reg;
    logic [CW-1:0]               rem_reg;
    logic [CW:0]                 trial;
    logic [CW:0]                 trial_sub;
    logic [CW-1:0]               rem_next;

    // Shift in the next dividend bit and subtract where it fits
    assign trial     = {rem_reg, dvd_reg[bale_pkg::AMT_W-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[CW-1:0] : trial[CW-1:0];

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(bale_pkg::AMT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold the partial remainder and the remaining dividend bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[bale_pkg::AMT_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/bale_dp.sv */
// ----------------------------------------------------------------------------
// bale_dp
// List datapath: request registers, entry count, two entry banks, removed
// value, remainder unit and the result register.
// ----------------------------------------------------------------------------
module bale_dp #(
    parameter int CAPACITY = bale_pkg::DEF_CAPACITY,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request fields
    input  logic [bale_pkg::ACT_W-1:0]         req_action,
    input  logic signed [bale_pkg::VAL_W-1:0]  req_item_value,
    input  logic [bale_pkg::POS_W-1:0]         req_position,
    input  logic [bale_pkg::AMT_W-1:0]         req_rotate_amount,
    // controller side
    input  bale_pkg::ctrl_cmd_t                cmd,
    input  logic [IW-1:0]                      rd_addr,
    input  logic [IW-1:0]                      wr_addr,
    input  logic [IW-1:0]                      out_idx,
    output bale_pkg::dp_stat_t                 stat,
    output logic [CW-1:0]                      count,
    output logic [CW-1:0]                      mod_rem,
    // result side
    input  logic                               rsp_ready,
    output logic                               rsp_valid,
    output logic [bale_pkg::ST_W-1:0]          rsp_status,
    output logic signed [bale_pkg::VAL_W-1:0]  rsp_result_value,
    output logic [bale_pkg::IDX_OUT_W-1:0]     rsp_result_index,
    output logic [bale_pkg::CNT_OUT_W-1:0]     rsp_entries_now,
    output logic                               rsp_last_of_run
);

    logic [bale_pkg::ACT_W-1:0]        action_reg;
    logic [bale_pkg::VAL_W-1:0]        value_reg;
    logic [bale_pkg::POS_W-1:0]        pos_reg;
    logic [bale_pkg::AMT_W-1:0]        amt_reg;
    logic [CW-1:0]                     count_reg;
    logic                              bank_reg;
    logic [bale_pkg::VAL_W-1:0]        bank0_reg [CAPACITY];
    logic [bale_pkg::VAL_W-1:0]        bank1_reg [CAPACITY];
    logic [bale_pkg::VAL_W-1:0]        q0_reg;
    logic [bale_pkg::VAL_W-1:0]        q1_reg;
    logic [bale_pkg::VAL_W-1:0]        removed_reg;
    logic                              out_valid_reg;
    logic [bale_pkg::ST_W-1:0]         out_status_reg;
    logic [bale_pkg::VAL_W-1:0]        out_value_reg;
    logic [bale_pkg::IDX_OUT_W-1:0]    out_index_reg;
    logic [bale_pkg::CNT_OUT_W-1:0]    out_entries_reg;
    logic                              out_last_reg;

    logic [bale_pkg::VAL_W-1:0]        rd_data;
    logic [bale_pkg::VAL_W-1:0]        wr_data;
    logic                              wr_bank;
    logic                              mod_done;
    logic                              out_free;
    logic [IW+bale_pkg::IDX_OUT_W-1:0] idx_ext;
    logic [CW+bale_pkg::CNT_OUT_W-1:0] cnt_ext;

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            action_reg <= req_action;
            value_reg  <= req_item_value;
            pos_reg    <= req_position;
            amt_reg    <= req_rotate_amount;
        end
    end

    // Entry count and active bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
                count_reg <= count_reg + CW'(1);
            else if (cmd.cnt_dec)
                count_reg <= count_reg - CW'(1);
            if (cmd.bank_flip)
                bank_reg <= ~bank_reg;
        end
    end

    // Entry banks: one write, one registered read each
    assign rd_data = bank_reg ? q1_reg : q0_reg;
    assign wr_data = cmd.wr_item ? value_reg : rd_data;
    assign wr_bank = bank_reg ^ cmd.wr_other;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !wr_bank)
            bank0_reg[wr_addr] <= wr_data;
        if (cmd.wr_en && wr_bank)
            bank1_reg[wr_addr] <= wr_data;
        if (cmd.rd_en)
        begin
            q0_reg <= bank0_reg[rd_addr];
            q1_reg <= bank1_reg[rd_addr];
        end
    end

    // Removed value for delete results
    always_ff @(posedge clk)
    begin
        if (cmd.clr_removed)
            removed_reg <= '0;
        else if (cmd.cap_removed)
            removed_reg <= rd_data;
    end

    // Rotate amount reduced modulo the count
    bale_mod #(
        .CW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (amt_reg),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Result register
    assign out_free = !out_valid_reg || rsp_ready;
    assign idx_ext  = {{bale_pkg::IDX_OUT_W{1'b0}}, out_idx};
    assign cnt_ext  = {{bale_pkg::CNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_value_reg   <= cmd.out_list ? rd_data : removed_reg;
            out_index_reg   <= idx_ext[bale_pkg::IDX_OUT_W-1:0];
            out_entries_reg <= cnt_ext[bale_pkg::CNT_OUT_W-1:0];
            out_last_reg    <= cmd.out_last;
        end
    end

    // Status to the controller
    assign stat.action   = action_reg;
    assign stat.position = pos_reg;
    assign stat.rd_match = (rd_data == value_reg);
    assign stat.out_free = out_free;
    assign stat.mod_done = mod_done;
    assign count         = count_reg;

    assign rsp_valid        = out_valid_reg;
    assign rsp_status       = out_status_reg;
    assign rsp_result_value = out_value_reg;
    assign rsp_result_index = out_index_reg;
    assign rsp_entries_now  = out_entries_reg;
    assign rsp_last_of_run  = out_last_reg;

endmodule

/* rtl/bale_ctrl.sv */
// ----------------------------------------------------------------------------
// bale_ctrl
// List controller: decodes each action, walks the entry banks for shifts,
// rotates, searches and listings, and orders the results.
// ----------------------------------------------------------------------------
module bale_ctrl #(
    parameter int CAPACITY = bale_pkg::DEF_CAPACITY,
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  bale_pkg::dp_stat_t   stat,
    input  logic [CW-1:0]        count,
    input  logic [CW-1:0]        mod_rem,
    output bale_pkg::ctrl_cmd_t  cmd,
    output logic [IW-1:0]        rd_addr,
    output logic [IW-1:0]        wr_addr,
    output logic [IW-1:0]        out_idx
);

    localparam int XW = (CW > bale_pkg::POS_W) ? CW : bale_pkg::POS_W;
    localparam int LW = bale_pkg::CNT_OUT_W;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_MOD      = 11'b000_0000_0100,
        S_DEL_RD   = 11'b000_0000_1000,
        S_DEL_CAP  = 11'b000_0001_0000,
        S_COPY     = 11'b000_0010_0000,
        S_SEARCH   = 11'b000_0100_0000,
        S_FINISH   = 11'b000_1000_0000,
        S_EMIT     = 11'b001_0000_0000,
        S_LIST_RD  = 11'b010_0000_0000,
        S_LIST_OUT = 11'b100_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [IW-1:0]              rd_addr_reg, rd_addr_next;
    logic [IW-1:0]              wr_addr_reg, wr_addr_next;
    logic [CW-1:0]              rd_left_reg, rd_left_next;
    logic                       pend_reg, pend_next;
    logic                       up_reg, up_next;
    logic                       rot_reg, rot_next;
    logic                       fin_ins_reg, fin_ins_next;
    logic                       fin_del_reg, fin_del_next;
    logic                       fin_rot_reg, fin_rot_next;
    logic [bale_pkg::ST_W-1:0]  status_reg, status_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [IW-1:0]              ins_addr_reg, ins_addr_next;
    logic [LW-1:0]              list_left_reg, list_left_next;

    logic [XW-1:0]              n_x;
    logic [XW-1:0]              pos_x;
    logic [XW-1:0]              peff_x;
    logic                       full;
    logic                       empty;
    logic [IW-1:0]              rd_inc;
    logic [LW-1:0]              list_n;

    // Decode helpers
    assign n_x    = XW'(count);
    assign pos_x  = XW'(stat.position);
    assign full   = (n_x >= XW'(CAPACITY));
    assign empty  = (count == '0);
    assign rd_inc = (rd_addr_reg == IW'(n_x - XW'(1))) ? '0 : rd_addr_reg + IW'(1);
    assign list_n = (n_x > XW'(bale_pkg::LIST_MAX)) ? LW'(bale_pkg::LIST_MAX) : LW'(n_x);

    // Effective position for the front/back/at forms
    always_comb
    begin
        case (stat.action)
            bale_pkg::ACT_INS_FRONT, bale_pkg::ACT_DEL_FRONT: peff_x = '0;
            bale_pkg::ACT_INS_BACK:                           peff_x = n_x;
            bale_pkg::ACT_DEL_BACK:                           peff_x = n_x - XW'(1);
            default:                                          peff_x = pos_x;
        endcase
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        rd_left_next   = rd_left_reg;
        pend_next      = 1'b0;
        up_next        = up_reg;
        rot_next       = rot_reg;
        fin_ins_next   = fin_ins_reg;
        fin_del_next   = fin_del_reg;
        fin_rot_next   = fin_rot_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        ins_addr_next  = ins_addr_reg;
        list_left_next = list_left_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        rd_addr        = rd_addr_reg;
        wr_addr        = wr_addr_reg;
        out_idx        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                cmd.clr_removed = 1'b1;
                status_next     = bale_pkg::ST_OK;
                idx_next        = '0;
                fin_ins_next    = 1'b0;
                fin_del_next    = 1'b0;
                fin_rot_next    = 1'b0;
                up_next         = 1'b0;
                rot_next        = 1'b0;
                state_next      = S_EMIT;
                case (stat.action)
                    bale_pkg::ACT_INS_FRONT, bale_pkg::ACT_INS_BACK,
                    bale_pkg::ACT_INS_AT:
                    begin
                        if (full)
                            status_next = bale_pkg::ST_FULL;
                        else if (peff_x > n_x)
                            status_next = bale_pkg::ST_BADPOS;
                        else
                        begin
                            // shift entries at and above the position up by one
                            rd_addr_next  = IW'(n_x - XW'(1));
                            wr_addr_next  = IW'(n_x);
                            rd_left_next  = CW'(n_x - peff_x);
                            up_next       = 1'b1;
                            fin_ins_next  = 1'b1;
                            ins_addr_next = IW'(peff_x);
                            state_next    = S_COPY;
                        end
                    end

                    bale_pkg::ACT_DEL_FRONT, bale_pkg::ACT_DEL_BACK,
                    bale_pkg::ACT_DEL_AT:
                    begin
                        if (empty)
                            status_next = bale_pkg::ST_EMPTY;
                        else if (peff_x >= n_x)
                            status_next = bale_pkg::ST_BADPOS;
                        else
                        begin
                            rd_addr_next = IW'(peff_x);
                            rd_left_next = CW'(n_x - peff_x - XW'(1));
                            fin_del_next = 1'b1;
                            state_next   = S_DEL_RD;
                        end
                    end

                    bale_pkg::ACT_SEARCH:
                    begin
                        status_next = bale_pkg::ST_NOTFOUND;
                        if (!empty)
                        begin
                            rd_addr_next = '0;
                            wr_addr_next = '0;
                            rd_left_next = count;
                            state_next   = S_SEARCH;
                        end
                    end

                    bale_pkg::ACT_LIST_ALL:
                    begin
                        if (empty)
                            status_next = bale_pkg::ST_EMPTY;
                        else
                        begin
                            rd_addr_next   = '0;
                            list_left_next = list_n;
                            state_next     = S_LIST_RD;
                        end
                    end

                    bale_pkg::ACT_ROTATE:
                    begin
                        if (empty)
                            status_next = bale_pkg::ST_EMPTY;
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                    end

                    default:
                    begin
                        status_next = bale_pkg::ST_OK;
                    end
                endcase
            end

            S_MOD:
            begin
                if (stat.mod_done)
                begin
                    if (mod_rem == '0)
                        state_next = S_EMIT;
                    else
                    begin
                        // copy into the other bank starting at the rotate offset
                        rd_addr_next = IW'(mod_rem);
                        wr_addr_next = '0;
                        rd_left_next = count;
                        rot_next     = 1'b1;
                        fin_rot_next = 1'b1;
                        state_next   = S_COPY;
                    end
                end
            end

            S_DEL_RD:
            begin
                cmd.rd_en    = 1'b1;
                wr_addr_next = rd_addr_reg;
                rd_addr_next = rd_inc;
                state_next   = S_DEL_CAP;
            end

            S_DEL_CAP:
            begin
                cmd.cap_removed = 1'b1;
                state_next      = S_COPY;
            end

            S_COPY:
            begin
                // issue the next read, write back the one in flight
                if (rd_left_reg != '0)
                begin
                    cmd.rd_en    = 1'b1;
                    rd_addr_next = up_reg ? rd_addr_reg - IW'(1) : rd_inc;
                    rd_left_next = rd_left_reg - CW'(1);
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_other = rot_reg;
                    wr_addr_next = up_reg ? wr_addr_reg - IW'(1) : wr_addr_reg + IW'(1);
                end
                if (rd_left_reg == '0 && !pend_reg)
                    state_next = S_FINISH;
            end

            S_SEARCH:
            begin
                if (rd_left_reg != '0)
                begin
                    cmd.rd_en    = 1'b1;
                    rd_addr_next = rd_inc;
                    rd_left_next = rd_left_reg - CW'(1);
                    pend_next    = 1'b1;
                end
                if (pend_reg && stat.rd_match)
                begin
                    status_next = bale_pkg::ST_OK;
                    idx_next    = wr_addr_reg;
                    pend_next   = 1'b0;
                    state_next  = S_EMIT;
                end
                else
                begin
                    if (pend_reg)
                        wr_addr_next = wr_addr_reg + IW'(1);
                    if (rd_left_reg == '0 && !pend_reg)
                        state_next = S_EMIT;
                end
            end

            S_FINISH:
            begin
                if (fin_ins_reg)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_item = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    wr_addr     = ins_addr_reg;
                end
                cmd.cnt_dec   = fin_del_reg;
                cmd.bank_flip = fin_rot_reg;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = status_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LIST_OUT;
            end

            S_LIST_OUT:
            begin
                out_idx = rd_addr_reg;
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_list   = 1'b1;
                    cmd.out_status = bale_pkg::ST_OK;
                    cmd.out_last   = (list_left_reg == LW'(1));
                    if (list_left_reg == LW'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        rd_addr_next   = rd_inc;
                        list_left_next = list_left_reg - LW'(1);
                        state_next     = S_LIST_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_addr_reg   <= '0;
            wr_addr_reg   <= '0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            up_reg        <= 1'b0;
            rot_reg       <= 1'b0;
            fin_ins_reg   <= 1'b0;
            fin_del_reg   <= 1'b0;
            fin_rot_reg   <= 1'b0;
            status_reg    <= bale_pkg::ST_OK;
            idx_reg       <= '0;
            ins_addr_reg  <= '0;
            list_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            wr_addr_reg   <= wr_addr_next;
            rd_left_reg   <= rd_left_next;
            pend_reg      <= pend_next;
            up_reg        <= up_next;
            rot_reg       <= rot_next;
            fin_ins_reg   <= fin_ins_next;
            fin_del_reg   <= fin_del_next;
            fin_rot_reg   <= fin_rot_next;
            status_reg    <= status_next;
            idx_reg       <= idx_next;
            ins_addr_reg  <= ins_addr_next;
            list_left_reg <= list_left_next;
        end
    end

endmodule

/* rtl/bounded_array_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit
// Packed list of up to CAPACITY signed 32-bit entries with insert, delete,
// search, listing and rotate actions.
// ----------------------------------------------------------------------------
// Usage
//   req : one action per transfer (action, item_value, position,
//         rotate_amount). Ready is high only in idle, so a new request is
//         taken in the cycle after the previous result loads; an action may
//         start while that result still waits.
//   rsp : one result per action; a listing gives one result per entry (at
//         most 16), last_of_run marks the final one.
// Shift, rotate and search walks move one entry per cycle; rotate copies
// to the other bank and swaps. Reset empties the list and drops any
// pending result; entry contents are left as they are. A stalled
// receiver holds the result register, and the block waits on it before
// loading the next result.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_unit #(
    parameter int CAPACITY = bale_pkg::DEF_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    bale_req_if.sink    req,
    bale_rsp_if.source  rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    bale_pkg::ctrl_cmd_t  cmd;
    bale_pkg::dp_stat_t   stat;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_addr;
    logic [IW-1:0]        out_idx;
    logic [CW-1:0]        count;
    logic [CW-1:0]        mod_rem;
    logic                 req_ready;

    assign req.ready = req_ready;

    // Sequencing
    bale_ctrl #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .count     (count),
        .mod_rem   (mod_rem),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .out_idx   (out_idx)
    );

    // Storage and result register
    bale_dp #(
        .CAPACITY (CAPACITY),
        .IW       (IW),
        .CW       (CW)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .req_action        (req.action),
        .req_item_value    (req.item_value),
        .req_position      (req.position),
        .req_rotate_amount (req.rotate_amount),
        .cmd               (cmd),
        .rd_addr           (rd_addr),
        .wr_addr           (wr_addr),
        .out_idx           (out_idx),
        .stat              (stat),
        .count             (count),
        .mod_rem           (mod_rem),
        .rsp_ready         (rsp.ready),
        .rsp_valid         (rsp.valid),
        .rsp_status        (rsp.status),
        .rsp_result_value  (rsp.result_value),
        .rsp_result_index  (rsp.result_index),
        .rsp_entries_now   (rsp.entries_now),
        .rsp_last_of_run   (rsp.last_of_run)
    );

    // Count never goes beyond the list depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    // One action at a time: no new request straight after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an action is in progress");

    // Error results always close their run
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != bale_pkg::ST_OK) |-> rsp.last_of_run)
        else $error("error result not marked last");

    // Count moves only by one between edges
    assert property (@(posedge clk) disable iff (!rst_n)
        (count != $past(count)) |->
            (count == $past(count) + CW'(1) || count == $past(count) - CW'(1)))
        else $error("entry count jumped");

endmodule
